// ----- rtl/sscu_pkg.sv -----
package sscu_pkg;

   localparam int PathDepthDefault = 1024;
   localparam int CordicStepsDefault = 16;
   localparam int AtanEntries = 24;

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] CSR_GAIN = 2'd0;
   localparam logic [1:0] CSR_OFFSET = 2'd1;
   localparam logic [1:0] CSR_HSCALE = 2'd2;

   localparam logic signed [33:0] CordicInvGain = 34'sd652032874;
   localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
   localparam logic signed [33:0] HalfTurn = 34'sd2147483648;

   // datapath operation codes
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_SC_ITER = 4'd2;
   localparam logic [3:0] OP_FRONT_MUL = 4'd3;
   localparam logic [3:0] OP_FRONT_ADD = 4'd4;
   localparam logic [3:0] OP_SCAN = 4'd5;
   localparam logic [3:0] OP_CTE_MUL = 4'd6;
   localparam logic [3:0] OP_CTE_SUB = 4'd7;
   localparam logic [3:0] OP_TGT = 4'd8;
   localparam logic [3:0] OP_AT_MUL = 4'd9;
   localparam logic [3:0] OP_AT_INIT = 4'd10;
   localparam logic [3:0] OP_AT_ITER = 4'd11;
   localparam logic [3:0] OP_FINISH = 4'd12;

   typedef struct packed {
      logic [3:0] op;
      logic       first;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic iter_done;
      logic rd_valid;
   } status_type;

   function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0: r = 34'sd536870912;
         5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;
         5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;
         5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;
         5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;
         5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/stanley_steering_controller_unit.sv -----
// Stanley path tracking controller. Mode 0 transfers append a path point,
// mode 2 clears the path, mode 1 runs a control step: a CORDIC sin/cos of the yaw,
// a pipelined nearest-point scan over the stored points (one point per cycle through
// one memory read port), then a CORDIC atan2; CORDIC_STEPS is capped at 24. A step
// on an empty path answers right after its transfer. No new transfer is taken until
// the result has been taken. Ties in distance pick the later index; the target index
// never falls below the previous one.
module stanley_steering_controller_unit import sscu_pkg::*; #(
   parameter int PATH_DEPTH = PathDepthDefault,
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [15:0] req_point_heading,
   input  logic signed [31:0] req_vehicle_x,
   input  logic signed [31:0] req_vehicle_y,
   input  logic signed [15:0] req_vehicle_heading,
   input  logic signed [15:0] req_vehicle_speed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_steer_angle,
   output logic [9:0]         rsp_target_index,
   output logic signed [31:0] rsp_cross_track_error,
   output logic               rsp_no_path,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int CntW = $clog2(PATH_DEPTH + 1);

   logic [15:0] gain_ff, offset_ff;
   logic [8:0]  hscale_ff;
   logic        rv_ff;
   logic        accept, start, busy;
   cmd_type     cmd;
   status_type  status;
   logic [CntW-1:0] count;
   logic signed [16:0] steer;
   logic [9:0]  tgt;
   logic signed [31:0] cte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 16'd2048;
         offset_ff <= 16'd768;
         hscale_ff <= 9'd205;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN: gain_ff <= csr_data;
            CSR_OFFSET: offset_ff <= csr_data;
            CSR_HSCALE: hscale_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !busy && !rv_ff;
   assign accept = req_valid && req_ready;
   assign start = accept && req_mode == MODE_STEP && count != '0;

   sscu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .cmd(cmd), .status(status), .busy(busy)
   );

   sscu_datapath #(.PathDepth(PATH_DEPTH), .CordicSteps(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .wr_en(accept && req_mode == MODE_APPEND),
      .clr(accept && req_mode == MODE_CLEAR),
      .wr_x(req_point_x), .wr_y(req_point_y), .wr_h(req_point_heading),
      .cap(start),
      .veh_x(req_vehicle_x), .veh_y(req_vehicle_y),
      .veh_h(req_vehicle_heading), .veh_v(req_vehicle_speed),
      .gain(gain_ff), .offset(offset_ff), .hscale(hscale_ff),
      .count(count), .steer(steer), .tgt_out(tgt), .cte_out(cte)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (accept && req_mode == MODE_STEP && count == '0) rv_ff <= 1'b1;
      else if (cmd.op == OP_FINISH) rv_ff <= 1'b1;
      else if (rsp_ready) rv_ff <= 1'b0;
   end

   logic np_ff;
   always_ff @(posedge clock) begin
      if (accept) np_ff <= (count == '0);
   end

   assign rsp_valid = rv_ff;
   assign rsp_no_path = np_ff;
   assign rsp_steer_angle = np_ff ? '0 : steer;
   assign rsp_target_index = np_ff ? '0 : tgt;
   assign rsp_cross_track_error = np_ff ? '0 : cte;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("input taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_ready) |=> rv_ff)
      else $error("result dropped");
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_STEP && count == '0) |=> (rsp_valid && rsp_no_path))
      else $error("empty path result missing");
`endif

endmodule

// ----- rtl/sscu_ctrl.sv -----
module sscu_ctrl import sscu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output cmd_type    cmd,
   input  status_type status,
   output logic       busy
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_SC = 4'd2;
   localparam logic [3:0] S_FMUL = 4'd3;
   localparam logic [3:0] S_FADD = 4'd4;
   localparam logic [3:0] S_SCAN = 4'd5;
   localparam logic [3:0] S_CMUL = 4'd6;
   localparam logic [3:0] S_CSUB = 4'd7;
   localparam logic [3:0] S_TGT = 4'd8;
   localparam logic [3:0] S_AMUL = 4'd9;
   localparam logic [3:0] S_AINIT = 4'd10;
   localparam logic [3:0] S_AT = 4'd11;
   localparam logic [3:0] S_FIN = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       first_ff, first_in;

   // sequencing of one control step
   always_comb begin
      state_in = state_ff;
      first_in = 1'b0;
      cmd.op = OP_NONE;
      cmd.first = first_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_LOAD;
         S_LOAD: begin
            cmd.op = OP_LOAD;
            state_in = S_SC;
         end
         S_SC: begin
            cmd.op = OP_SC_ITER;
            if (status.iter_done) state_in = S_FMUL;
         end
         S_FMUL: begin
            cmd.op = OP_FRONT_MUL;
            state_in = S_FADD;
         end
         S_FADD: begin
            cmd.op = OP_FRONT_ADD;
            state_in = S_SCAN;
            first_in = 1'b1;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (status.scan_done) state_in = S_CMUL;
         end
         S_CMUL: begin
            cmd.op = OP_CTE_MUL;
            state_in = S_CSUB;
         end
         S_CSUB: begin
            cmd.op = OP_CTE_SUB;
            state_in = S_TGT;
         end
         S_TGT: begin
            cmd.op = OP_TGT;
            state_in = S_AMUL;
         end
         S_AMUL: begin
            cmd.op = OP_AT_MUL;
            state_in = S_AINIT;
         end
         S_AINIT: begin
            cmd.op = OP_AT_INIT;
            state_in = S_AT;
         end
         S_AT: begin
            cmd.op = OP_AT_ITER;
            if (status.iter_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op = OP_FINISH;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> (state_ff == S_LOAD))
      else $error("start not taken");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> (state_ff == S_IDLE))
      else $error("finish not followed by idle");
   a_scan_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FADD) |=> (state_ff == S_SCAN && first_ff))
      else $error("scan entered without first flag");
`endif

endmodule

// ----- rtl/sscu_datapath.sv -----
module sscu_datapath import sscu_pkg::*; #(
   parameter int PathDepth = PathDepthDefault,
   parameter int CordicSteps = CordicStepsDefault,
   localparam int IdxW = $clog2(PathDepth),
   localparam int CntW = $clog2(PathDepth + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               wr_en,
   input  logic               clr,
   input  logic signed [31:0] wr_x,
   input  logic signed [31:0] wr_y,
   input  logic signed [15:0] wr_h,
   input  logic               cap,
   input  logic signed [31:0] veh_x,
   input  logic signed [31:0] veh_y,
   input  logic signed [15:0] veh_h,
   input  logic signed [15:0] veh_v,
   input  logic [15:0]        gain,
   input  logic [15:0]        offset,
   input  logic [8:0]         hscale,
   output logic [CntW-1:0]    count,
   output logic signed [16:0] steer,
   output logic [9:0]         tgt_out,
   output logic signed [31:0] cte_out
);

   localparam int NSteps = (CordicSteps > AtanEntries) ? AtanEntries : CordicSteps;
   localparam int ItW = $clog2(NSteps + 1);

   // path memories
   logic signed [31:0] mem_x [PathDepth];
   logic signed [31:0] mem_y [PathDepth];
   logic signed [15:0] mem_h [PathDepth];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic signed [15:0] rd_h_ff;
   logic [IdxW-1:0]    rd_addr;

   logic [CntW-1:0] count_ff;
   logic [IdxW-1:0] last_ff;

   // captured pose
   logic signed [31:0] vx_ff, vy_ff;
   logic signed [15:0] vh_ff, vv_ff;

   // cordic; wide enough for gain * error in vectoring mode
   logic signed [49:0] cx_ff, cy_ff;
   logic signed [34:0] cz_ff;
   logic               flip_ff;
   logic [ItW-1:0]     it_ff;

   logic signed [33:0] cos_ff, sin_ff;
   logic signed [50:0] px_ff, py_ff;
   logic signed [33:0] fx_ff, fy_ff;

   // scan
   logic [CntW-1:0]    sidx_ff;
   logic               pend_ff;
   logic [IdxW-1:0]    pidx_ff;
   logic [66:0]        bd_ff;
   logic [IdxW-1:0]    best_ff;
   logic signed [33:0] bdx_ff, bdy_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic [IdxW-1:0]    didx_ff;
   logic               dv_ff;
   logic [65:0]        sx_ff, sy_ff;
   logic [IdxW-1:0]    sqidx_ff;
   logic               sqv_ff;
   logic signed [33:0] sqdx_ff, sqdy_ff;

   logic signed [57:0] m1_ff, m2_ff;
   logic signed [31:0] cte_ff;
   logic [IdxW-1:0]    tgt_ff;
   logic signed [16:0] te_ff;
   logic signed [48:0] aty_ff;
   logic signed [36:0] atx_ff;

   logic signed [16:0] steer_ff;

   assign count = count_ff;

   // write / read of the path store
   always_ff @(posedge clock) begin
      if (wr_en && count_ff < CntW'(PathDepth)) begin
         mem_x[count_ff[IdxW-1:0]] <= wr_x;
         mem_y[count_ff[IdxW-1:0]] <= wr_y;
         mem_h[count_ff[IdxW-1:0]] <= wr_h;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_h_ff <= mem_h[rd_addr];
   end

   assign rd_addr = (cmd.op == OP_SCAN) ? sidx_ff[IdxW-1:0] : tgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff <= '0;
      end else if (clr) begin
         count_ff <= '0;
         last_ff <= '0;
      end else if (wr_en && count_ff < CntW'(PathDepth)) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.op == OP_FINISH) begin
         last_ff <= tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cap) begin
         vx_ff <= veh_x;
         vy_ff <= veh_y;
         vh_ff <= veh_h;
         vv_ff <= veh_v;
      end
   end

   // cordic shared for rotation and vectoring
   logic signed [33:0] z0;
   logic signed [49:0] xs, ys;
   logic signed [34:0] at;
   logic               dir;
   always_comb begin
      z0 = {{2{vh_ff[15]}}, vh_ff, 16'd0};
      xs = cx_ff >>> it_ff;
      ys = cy_ff >>> it_ff;
      at = 35'(atan_entry(5'(it_ff)));
      if (cmd.op == OP_SC_ITER) dir = !cz_ff[34];
      else dir = (cy_ff > 50'sd0);
   end

   assign status.iter_done = (it_ff == ItW'(NSteps - 1));
   assign status.rd_valid = pend_ff;

   logic [66:0]        sq_dist;
   logic signed [33:0] qdx, qdy;
   logic               scan_end;
   assign sq_dist = {1'b0, sx_ff} + {1'b0, sy_ff};
   assign scan_end = (sidx_ff >= count_ff) && !pend_ff && !dv_ff && !sqv_ff;
   assign status.scan_done = scan_end && !cmd.first;
   assign qdx = fx_ff - 34'(rd_x_ff);
   assign qdy = fy_ff - 34'(rd_y_ff);

   logic [33:0] adx, ady;
   assign adx = dx_ff[33] ? 34'(-dx_ff) : 34'(dx_ff);
   assign ady = dy_ff[33] ? 34'(-dy_ff) : 34'(dy_ff);

   logic signed [58:0] cdiff;
   logic signed [39:0] cte_w;
   logic signed [24:0] hep;
   logic signed [15:0] he;
   logic signed [26:0] z_rnd;
   assign cdiff = 59'(m1_ff) - 59'(m2_ff);
   assign cte_w = 40'(cdiff >>> 20);
   assign he = rd_h_ff - vh_ff;
   assign hep = he * $signed({1'b0, hscale});
   assign z_rnd = 27'((cz_ff + 35'sd32768) >>> 16);

   logic [IdxW-1:0] tsel;
   always_comb begin
      tsel = (last_ff >= best_ff) ? last_ff : best_ff;
      if (CntW'(tsel) >= count_ff) tsel = IdxW'(count_ff - 1'b1);
   end

   logic signed [17:0] ssum;
   assign ssum = 18'(te_ff) + 18'(z_rnd);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cx_ff <= 50'(CordicInvGain);
            cy_ff <= '0;
            it_ff <= '0;
            if (z0 > QuarterTurn) begin
               cz_ff <= 35'(z0) - 35'(HalfTurn);
               flip_ff <= 1'b1;
            end else if (z0 < -QuarterTurn) begin
               cz_ff <= 35'(z0) + 35'(HalfTurn);
               flip_ff <= 1'b1;
            end else begin
               cz_ff <= 35'(z0);
               flip_ff <= 1'b0;
            end
         end
         OP_SC_ITER, OP_AT_ITER: begin
            it_ff <= it_ff + 1'b1;
            if (dir) begin
               cx_ff <= (cmd.op == OP_SC_ITER) ? cx_ff - ys : cx_ff + ys;
               cy_ff <= (cmd.op == OP_SC_ITER) ? cy_ff + xs : cy_ff - xs;
               cz_ff <= (cmd.op == OP_SC_ITER) ? cz_ff - at : cz_ff + at;
            end else begin
               cx_ff <= (cmd.op == OP_SC_ITER) ? cx_ff + ys : cx_ff - ys;
               cy_ff <= (cmd.op == OP_SC_ITER) ? cy_ff - xs : cy_ff + xs;
               cz_ff <= (cmd.op == OP_SC_ITER) ? cz_ff + at : cz_ff - at;
            end
         end
         OP_FRONT_MUL: begin
            cos_ff <= flip_ff ? 34'(-cx_ff) : 34'(cx_ff);
            sin_ff <= flip_ff ? 34'(-cy_ff) : 34'(cy_ff);
            px_ff <= $signed({1'b0, offset})
               * 51'(flip_ff ? 34'(-cx_ff) : 34'(cx_ff));
            py_ff <= $signed({1'b0, offset})
               * 51'(flip_ff ? 34'(-cy_ff) : 34'(cy_ff));
         end
         OP_FRONT_ADD: begin
            fx_ff <= 34'(vx_ff) + 34'(px_ff >>> 22);
            fy_ff <= 34'(vy_ff) + 34'(py_ff >>> 22);
            sidx_ff <= '0;
            pend_ff <= 1'b0;
            dv_ff <= 1'b0;
            sqv_ff <= 1'b0;
         end
         OP_SCAN: begin
            // stage 0: issue read
            pend_ff <= (sidx_ff < count_ff);
            pidx_ff <= sidx_ff[IdxW-1:0];
            if (sidx_ff < count_ff) sidx_ff <= sidx_ff + 1'b1;
            // stage 1: differences
            dv_ff <= pend_ff;
            dx_ff <= qdx;
            dy_ff <= qdy;
            didx_ff <= pidx_ff;
            // stage 2: squares
            sqv_ff <= dv_ff;
            sx_ff <= adx * adx;
            sy_ff <= ady * ady;
            sqidx_ff <= didx_ff;
            sqdx_ff <= dx_ff;
            sqdy_ff <= dy_ff;
            // stage 3: compare, later index wins ties
            if (sqv_ff && (sqidx_ff == '0 || sq_dist <= bd_ff)) begin
               bd_ff <= sq_dist;
               best_ff <= sqidx_ff;
               bdx_ff <= sqdx_ff;
               bdy_ff <= sqdy_ff;
            end
         end
         OP_CTE_MUL: begin
            m1_ff <= bdx_ff * 24'(sin_ff >>> 10);
            m2_ff <= bdy_ff * 24'(cos_ff >>> 10);
         end
         OP_CTE_SUB: begin
            if (cte_w > 40'sd2147483647) cte_ff <= 32'sh7FFFFFFF;
            else if (cte_w < -40'sd2147483648) cte_ff <= 32'sh80000000;
            else cte_ff <= 32'(cte_w);
            tgt_ff <= tsel;
         end
         OP_TGT: begin
            // read data of target heading becomes valid next cycle
         end
         OP_AT_MUL: begin
            te_ff <= 17'(hep >>> 8);
            aty_ff <= $signed({1'b0, gain}) * cte_ff;
            atx_ff <= 37'(vv_ff) <<< 20;
         end
         OP_AT_INIT: begin
            it_ff <= '0;
            if (atx_ff < 0) begin
               cz_ff <= (aty_ff >= 0) ? 35'(HalfTurn) : -35'(HalfTurn);
               cx_ff <= 50'(-atx_ff);
               cy_ff <= 50'(-aty_ff);
            end else begin
               cz_ff <= '0;
               cx_ff <= 50'(atx_ff);
               cy_ff <= 50'(aty_ff);
            end
         end
         OP_FINISH: begin
            // zero vector: the angle term is zero, heading term always fits
            if (atx_ff == 0 && aty_ff == 0) steer_ff <= te_ff;
            else if (ssum > 18'sd65535) steer_ff <= 17'sd65535;
            else if (ssum < -18'sd65536) steer_ff <= -17'sd65536;
            else steer_ff <= 17'(ssum);
         end
         default: ;
      endcase
   end

   assign steer = steer_ff;
   assign tgt_out = 10'(tgt_ff);
   assign cte_out = cte_ff;

endmodule

// ----- dv/tb_stanley_steering_controller_unit.sv -----
module tb_stanley_steering_controller_unit import sscu_pkg::*;;

   localparam int DEPTH = 1024;
   localparam int STEPS = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES = 1200;

   // mode with no function: no result, no change to the path
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // arctangent of 2^-i, 2^31 = pi
   localparam longint AtanLut [STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861};

   typedef struct {
      logic [1:0]         mode;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [15:0] ph;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [15:0] vh;
      logic signed [15:0] vs;
   } path_req_type;

   typedef struct {
      logic signed [16:0] steer;
      logic [9:0]         tgt;
      logic signed [31:0] cte;
      logic               no_path;
   } steer_cmd_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_APPEND;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [15:0] req_point_heading = '0;
   logic signed [31:0] req_vehicle_x = '0;
   logic signed [31:0] req_vehicle_y = '0;
   logic signed [15:0] req_vehicle_heading = '0;
   logic signed [15:0] req_vehicle_speed = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_steer_angle;
   logic [9:0]         rsp_target_index;
   logic signed [31:0] rsp_cross_track_error;
   logic               rsp_no_path;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_GAIN;
   logic [15:0]        csr_data = '0;

   stanley_steering_controller_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] path_x_mem [DEPTH];
   logic signed [31:0] path_y_mem [DEPTH];
   logic signed [15:0] path_h_mem [DEPTH];
   int                 stored_points = 0;
   int                 prev_target = 0;
   longint             gain_reg = 2048;
   longint             offset_reg = 768;
   longint             hscale_reg = 205;

   steer_cmd_type      pending_cmds [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 quiet_cycles = 0;
   int                 items_sent = 0;
   int                 steps_sent = 0;
   int                 cmds_checked = 0;
   int                 settings_used = 0;

   // random idling, with a recurring long idle-free window
   function automatic bit idle_now();
      return ((cycle_count % 20000) >= 6000) && ($urandom_range(0, 99) < 12);
   endfunction

   // CORDIC rotation, results Q2.30
   function automatic void sin_cos(input logic signed [15:0] ang,
                                   output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit     flip;
      z = longint'($signed({ang, 16'h0000}));
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
         z = z - 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z = z + 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - AtanLut[i];
         end else begin
            x = x + ys; y = y - xs; z = z + AtanLut[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // CORDIC vectoring, result in 16-bit angle units
   function automatic longint vec_angle(input longint y0, input longint x0);
      longint x, y, z, xs, ys;
      x = x0;
      y = y0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + AtanLut[i];
         end else begin
            x = x - ys; y = y + xs; z = z - AtanLut[i];
         end
      end
      return (z + 32768) >>> 16;
   endfunction

   // control step: nearest point, cross-track error, steering
   function automatic steer_cmd_type control_step(input path_req_type r);
      steer_cmd_type      cmd;
      longint             c, s, fx, fy, dx, dy, bdx, bdy, cte, te, td, steer;
      logic [127:0]       ax, ay, d2, best_d2;
      logic signed [15:0] hdiff;
      int                 best, tgt;
      bdx = 0; bdy = 0; best = 0; best_d2 = '0;
      sin_cos(r.vh, c, s);
      fx = longint'(r.vx) + ((offset_reg * c) >>> 22);
      fy = longint'(r.vy) + ((offset_reg * s) >>> 22);
      for (int i = 0; i < stored_points; i++) begin
         dx = fx - longint'(path_x_mem[i]);
         dy = fy - longint'(path_y_mem[i]);
         ax = (dx < 0) ? 128'(-dx) : 128'(dx);
         ay = (dy < 0) ? 128'(-dy) : 128'(dy);
         d2 = ax * ax + ay * ay;
         // later index wins a tie
         if (i == 0 || d2 <= best_d2) begin
            best_d2 = d2; best = i; bdx = dx; bdy = dy;
         end
      end
      cte = (bdx * (s >>> 10) - bdy * (c >>> 10)) >>> 20;
      if (cte > 64'sd2147483647) cte = 64'sd2147483647;
      if (cte < -64'sd2147483648) cte = -64'sd2147483648;
      tgt = (prev_target >= best) ? prev_target : best;
      if (tgt >= stored_points) tgt = stored_points - 1;
      hdiff = path_h_mem[tgt] - r.vh;
      te = (longint'(hdiff) * hscale_reg) >>> 8;
      td = vec_angle(gain_reg * cte, longint'(r.vs) * 1048576);
      steer = te + td;
      if (steer > 65535) steer = 65535;
      if (steer < -65536) steer = -65536;
      prev_target = tgt;
      cmd.steer = steer[16:0];
      cmd.tgt = tgt[9:0];
      cmd.cte = cte[31:0];
      cmd.no_path = 1'b0;
      return cmd;
   endfunction

   // update the path model on an accepted transfer
   function automatic void predict(input path_req_type r);
      steer_cmd_type cmd;
      case (r.mode)
         MODE_APPEND: begin
            if (stored_points < DEPTH) begin
               path_x_mem[stored_points] = r.px;
               path_y_mem[stored_points] = r.py;
               path_h_mem[stored_points] = r.ph;
               stored_points++;
            end
         end
         MODE_CLEAR: begin
            stored_points = 0;
            prev_target = 0;
         end
         MODE_STEP: begin
            steps_sent++;
            if (stored_points == 0) begin
               cmd.steer = '0; cmd.tgt = '0; cmd.cte = '0; cmd.no_path = 1'b1;
            end else begin
               cmd = control_step(r);
            end
            pending_cmds = {pending_cmds, cmd};
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input path_req_type r);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_point_x <= r.px;
      req_point_y <= r.py;
      req_point_heading <= r.ph;
      req_vehicle_x <= r.vx;
      req_vehicle_y <= r.vy;
      req_vehicle_heading <= r.vh;
      req_vehicle_speed <= r.vs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict(r);
      if (r.mode != MODE_UNUSED) items_sent++;
   endtask

   // random request with every field full range
   function automatic path_req_type rand_req(input logic [1:0] mode);
      path_req_type r;
      r.mode = mode;
      r.px = $urandom; r.py = $urandom; r.ph = 16'($urandom);
      r.vx = $urandom; r.vy = $urandom; r.vh = 16'($urandom); r.vs = 16'($urandom);
      return r;
   endfunction

   task automatic send_point(input int x, input int y, input int h);
      path_req_type r;
      r = rand_req(MODE_APPEND);
      r.px = x; r.py = y; r.ph = 16'(h);
      send_item(r);
   endtask

   task automatic send_step(input int x, input int y, input int h, input int v);
      path_req_type r;
      r = rand_req(MODE_STEP);
      r.vx = x; r.vy = y; r.vh = 16'(h); r.vs = 16'(v);
      send_item(r);
   endtask

   // let every pending command come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_GAIN:   gain_reg = longint'(data);
         CSR_OFFSET: offset_reg = longint'(data);
         CSR_HSCALE: hscale_reg = longint'(data[8:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] g, input logic [15:0] o,
                                 input logic [15:0] h);
      drain();
      write_reg(CSR_GAIN, g);
      write_reg(CSR_OFFSET, o);
      write_reg(CSR_HSCALE, h);
      settings_used++;
   endtask

   // result checker and receiver stalls
   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      steer_cmd_type e;
      if (rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual steer %0d",
                     $time, rsp_steer_angle);
            error_count++;
         end else begin
            e = pending_cmds.pop_front();
            check_field("steer_angle", e.steer, rsp_steer_angle);
            check_field("target_index", e.tgt, rsp_target_index);
            check_field("cross_track_error", e.cte, rsp_cross_track_error);
            check_field("no_path", e.no_path, rsp_no_path);
            cmds_checked++;
         end
      end
      rsp_ready <= !idle_now();
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      cycle_count++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // extremes, empty path, ties, unused mode
   task automatic test_directed();
      path_req_type r;
      send_step(0, 0, 0, 256);
      send_point(32'sh7fffffff, 32'sh7fffffff, 32767);
      send_point(32'sh80000000, 32'sh80000000, -32768);
      send_step(32'sh7fffffff, 32'sh80000000, -32768, -32768);
      send_step(32'sh80000000, 32'sh7fffffff, 32767, 32767);
      send_step(32'sh80000000, 32'sh80000000, 16384, 0);
      r = rand_req(MODE_UNUSED);
      send_item(r);
      // equal points: later index wins
      send_item(rand_req(MODE_CLEAR));
      send_point(65536, 0, 100);
      send_point(65536, 0, -100);
      send_point(65536, 0, 8000);
      send_step(-65536, 0, 0, 512);
      send_step(-65536, 0, -16384, -512);
      send_item(rand_req(MODE_CLEAR));
      send_step(0, 0, 0, 256);
      send_point(0, 0, 0);
      send_step(0, 0, 0, 0);
   endtask

   // zero vector and negative speed at zero error
   task automatic test_zero_error();
      apply_settings(16'd2048, 16'd0, 16'd205);
      send_item(rand_req(MODE_CLEAR));
      send_point(131072, -65536, 4000);
      send_step(131072, -65536, 4000, 0);
      send_step(131072, -65536, -4000, -256);
      send_step(131072, -65536, 0, -32768);
      drain();
   endtask

   function automatic int near_coord();
      return int'($urandom_range(0, 1 << 25)) - (1 << 24);
   endfunction

   // one path: clear, append a trajectory, run steps along it, with some noise
   task automatic run_path_session();
      int n, steps, bx, by, sx, sy, h0, k;
      path_req_type r;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 24);
      bx = near_coord(); by = near_coord();
      sx = int'($urandom_range(0, 131072)) - 65536;
      sy = int'($urandom_range(0, 131072)) - 65536;
      h0 = $urandom_range(0, 65535);
      send_item(rand_req(MODE_CLEAR));
      if ($urandom_range(0, 7) == 0) send_item(rand_req(MODE_STEP));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(rand_req($urandom_range(0, 9) == 0 ? MODE_UNUSED : MODE_APPEND));
         else
            send_point(bx + i * sx + int'($urandom_range(0, 8191)) - 4096,
                       by + i * sy + int'($urandom_range(0, 8191)) - 4096,
                       h0 + i * int'($urandom_range(0, 400)));
      end
      steps = $urandom_range(3, 10);
      for (int j = 0; j < steps; j++) begin
         k = $urandom_range(0, n - 1);
         if ($urandom_range(0, 9) == 0)
            send_item(rand_req(MODE_STEP));
         else
            send_step(bx + k * sx + int'($urandom_range(0, 262144)) - 131072,
                      by + k * sy + int'($urandom_range(0, 262144)) - 131072,
                      h0 + k * 200 + int'($urandom_range(0, 12000)) - 6000,
                      ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, 65535)));
      end
   endtask

   // random sessions over several register settings, extremes among them
   task automatic test_random_paths(input int target_items);
      int phase;
      phase = 0;
      while (items_sent < target_items) begin
         case (phase % 6)
            0: apply_settings(16'd2048, 16'd768, 16'd205);
            1: apply_settings(16'd0, 16'd0, 16'd0);
            2: apply_settings(16'hffff, 16'hffff, 16'd256);
            3: apply_settings(16'hffff, 16'd1, 16'd511);
            default: apply_settings(16'($urandom), 16'($urandom),
                                    16'($urandom_range(0, 256)));
         endcase
         repeat (8) begin
            if (items_sent < target_items) run_path_session();
         end
         // hold off until every result is back
         if (phase == 2) drain();
         phase++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_zero_error();
      test_random_paths(540);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d request transfers, %0d control steps, %0d results checked,",
               items_sent, steps_sent, cmds_checked);
      $display("over %0d register settings including empty paths, ties and zero vectors",
               settings_used);
      if (error_count == 0 && pending_cmds.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
